// ----- design/rc_pkg.sv -----
package rc_pkg;

  localparam int MAP_DIM_DEF   = 16;
  localparam int POS_FRAC_DEF  = 12;

  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int COL_W   = 10;
  localparam int DIM_W   = 10;
  localparam int DIST_W  = 32;
  localparam int DN_W    = 40;
  localparam int CAM_W   = 27;
  localparam int RAY_W   = 30;
  localparam int CRD_W   = 12;
  localparam int LH_W    = 26;
  localparam int SLICE_W = 13;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [IDX_W-1:0] REG_POS_X      = 3'd0;
  localparam logic [IDX_W-1:0] REG_POS_Y      = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIR_X      = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIR_Y      = 3'd3;
  localparam logic [IDX_W-1:0] REG_PLANE_X    = 3'd4;
  localparam logic [IDX_W-1:0] REG_PLANE_Y    = 3'd5;
  localparam logic [IDX_W-1:0] REG_SCR_WIDTH  = 3'd6;
  localparam logic [IDX_W-1:0] REG_SCR_HEIGHT = 3'd7;

  typedef enum logic [2:0] {
    DS_CAM  = 3'd0,
    DS_INVX = 3'd1,
    DS_INVY = 3'd2,
    DS_PERP = 3'd3,
    DS_LINE = 3'd4
  } div_sel_t;

  typedef struct packed {
    logic     clr_wr;
    logic     item_load;
    logic     cell_wr;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul_x;
    logic     mul_y;
    logic     side_x;
    logic     side_y;
    logic     walk_step;
    logic     walk_end;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic walk_out;
    logic walk_wall;
    logic out_busy;
  } stat_t;

  function automatic logic [23:0] wall_rgb(input logic [2:0] t);
    logic [23:0] c;
    unique case (t)
      3'd0: c = {8'd0,   8'd0,   8'd0};
      3'd1: c = {8'd255, 8'd0,   8'd0};
      3'd2: c = {8'd0,   8'd255, 8'd0};
      3'd3: c = {8'd0,   8'd0,   8'd255};
      3'd4: c = {8'd255, 8'd255, 8'd255};
      3'd5: c = {8'd255, 8'd165, 8'd0};
      3'd6: c = {8'd128, 8'd0,   8'd128};
      3'd7: c = {8'd255, 8'd192, 8'd203};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- design/rc_div.sv -----
module rc_div
  import rc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DN_W-1:0]   num,
  input  logic [DIST_W-1:0] den,
  output logic              done,
  output logic [DN_W-1:0]   quot
);

  localparam int CNT_W = $clog2(DN_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIST_W-1:0] rem;
  logic [DIST_W-1:0] dvs;
  logic [DIST_W:0]   trial;
  logic [DIST_W:0]   diff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quot[DN_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= den;
      quot <= num;
    end else if (busy) begin
      if (!diff[DIST_W]) begin
        rem  <= diff[DIST_W-1:0];
        quot <= {quot[DN_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DIST_W-1:0];
        quot <= {quot[DN_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- design/rc_ctrl.sv -----
module rc_ctrl
  import rc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  opcode,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_CLR    = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_CAM    = 15'b000000000000100,
    S_MULX   = 15'b000000000001000,
    S_MULY   = 15'b000000000010000,
    S_INVX   = 15'b000000000100000,
    S_INVY   = 15'b000000001000000,
    S_SIDEX  = 15'b000000010000000,
    S_SIDEY  = 15'b000000100000000,
    S_STEP   = 15'b000001000000000,
    S_CHECK  = 15'b000010000000000,
    S_PERP   = 15'b000100000000000,
    S_LSTART = 15'b001000000000000,
    S_LINE   = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DS_CAM;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (opcode) begin
            cmd.item_load = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DS_CAM;
            state_next    = S_CAM;
          end else begin
            cmd.cell_wr = 1'b1;
          end
        end
      end
      S_CAM: if (st.div_done) state_next = S_MULX;
      S_MULX: begin
        cmd.mul_x  = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y     = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_INVX;
        state_next    = S_INVX;
      end
      S_INVX: begin
        if (st.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_INVY;
          state_next    = S_INVY;
        end
      end
      S_INVY: if (st.div_done) state_next = S_SIDEX;
      S_SIDEX: begin
        cmd.side_x = 1'b1;
        state_next = S_SIDEY;
      end
      S_SIDEY: begin
        cmd.side_y = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.walk_step = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (st.walk_out) begin
          cmd.walk_end = 1'b1;
          state_next   = S_DONE;
        end else if (st.walk_wall) begin
          cmd.walk_end  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_PERP;
          state_next    = S_PERP;
        end else begin
          state_next = S_STEP;
        end
      end
      S_PERP: if (st.div_done) state_next = S_LSTART;
      S_LSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_LINE;
        state_next    = S_LINE;
      end
      S_LINE: if (st.div_done) state_next = S_DONE;
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/rc_datapath.sv -----
module rc_datapath
  import rc_pkg::*;
#(
  parameter int MAP_DIM       = MAP_DIM_DEF,
  parameter int POS_FRAC_BITS = POS_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic [COL_W-1:0]          column,
  input  logic [3:0]                cell_x,
  input  logic [3:0]                cell_y,
  input  logic [2:0]                cell_value,
  input  cmd_t                      cmd,
  output stat_t                     st,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COL_W-1:0]          out_column,
  output logic                      wall_hit,
  output logic                      hit_side,
  output logic [2:0]                wall_type,
  output logic signed [SLICE_W-1:0] slice_start,
  output logic signed [SLICE_W-1:0] slice_end,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue
);

  localparam int DEPTH  = MAP_DIM * MAP_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int MAP_W  = $clog2(MAP_DIM);
  localparam int FRAC_W = POS_FRAC_BITS + 1;
  localparam int SP_W   = FRAC_W + DIST_W;
  localparam int EDGE_W = CRD_W + CFG_W + 1;

  // configuration registers
  logic [CFG_W-1:0]        pos_x, pos_y;
  logic signed [CFG_W-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [DIM_W-1:0]        scr_w, scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= 16'd34816;
      pos_y   <= 16'd34816;
      dir_x   <= 16'sd16384;
      dir_y   <= 16'sd0;
      plane_x <= 16'sd0;
      plane_y <= 16'sd10813;
      scr_w   <= 10'd220;
      scr_h   <= 10'd100;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POS_X:      pos_x   <= cfg_data;
        REG_POS_Y:      pos_y   <= cfg_data;
        REG_DIR_X:      dir_x   <= cfg_data;
        REG_DIR_Y:      dir_y   <= cfg_data;
        REG_PLANE_X:    plane_x <= cfg_data;
        REG_PLANE_Y:    plane_y <= cfg_data;
        REG_SCR_WIDTH:  scr_w   <= cfg_data[DIM_W-1:0];
        REG_SCR_HEIGHT: scr_h   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [RAY_W-1:0] mag(input logic signed [RAY_W-1:0] v);
    return v[RAY_W-1] ? RAY_W'(-v) : RAY_W'(v);
  endfunction

  function automatic logic signed [SLICE_W-1:0] clamp(input logic signed [LH_W+1:0] v);
    logic signed [SLICE_W-1:0] r;
    if (v < -(LH_W+2)'(4096))     r = -13'sd4096;
    else if (v > (LH_W+2)'(4095)) r = 13'sd4095;
    else                          r = v[SLICE_W-1:0];
    return r;
  endfunction

  // map store with clearing pass after reset
  logic [2:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic [2:0]    rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          cell_ok;
  logic [AW-1:0] cell_addr;

  assign cell_ok   = cmd.cell_wr && ({5'b0, cell_x} < 9'(MAP_DIM)) &&
                     ({5'b0, cell_y} < 9'(MAP_DIM));
  assign cell_addr = AW'(cell_x) * AW'(MAP_DIM) + AW'(cell_y);
  assign st.clr_last = (clr_addr == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst)              clr_addr <= '0;
    else if (cmd.clr_wr)  clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr)   mem[clr_addr]  <= '0;
    else if (cell_ok) mem[cell_addr] <= cell_value;
    if (rd_en)        rd_data <= mem[rd_addr];
  end

  // shared divider
  logic [DN_W-1:0]   div_num, div_q;
  logic [DIST_W-1:0] div_den;
  logic              div_done;
  div_sel_t          div_sel_q;

  logic [COL_W-1:0]         col_q;
  logic signed [CAM_W-1:0]  cam;
  logic signed [RAY_W-1:0]  ray_x, ray_y;
  logic [RAY_W-1:0]         rxm, rym;
  logic [DIST_W-1:0]        dx, dy, sdx, sdy, perp;
  logic signed [CRD_W-1:0]  mx, my;
  logic                     side, hit;
  logic [2:0]               wtype;
  logic [LH_W-1:0]          lh;
  logic [EDGE_W-1:0]        num_abs;
  logic signed [EDGE_W-1:0] edge_d;

  assign rxm = mag(ray_x);
  assign rym = mag(ray_y);

  always_comb begin
    if (!side)
      edge_d = (EDGE_W'(mx) + EDGE_W'(ray_x[RAY_W-1])) * EDGE_W'(2 ** POS_FRAC_BITS)
               - EDGE_W'(pos_x);
    else
      edge_d = (EDGE_W'(my) + EDGE_W'(ray_y[RAY_W-1])) * EDGE_W'(2 ** POS_FRAC_BITS)
               - EDGE_W'(pos_y);
    num_abs = edge_d[EDGE_W-1] ? EDGE_W'(-edge_d) : EDGE_W'(edge_d);
  end

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (cmd.div_sel)
      DS_CAM: begin
        div_num = DN_W'({column, 15'b0});
        div_den = (scr_w == '0) ? DIST_W'(1) : DIST_W'(scr_w);
      end
      DS_INVX: begin
        div_num = DN_W'(1) << 30;
        div_den = DIST_W'(rxm);
      end
      DS_INVY: begin
        div_num = DN_W'(1) << 30;
        div_den = DIST_W'(rym);
      end
      DS_PERP: begin
        div_num = DN_W'(num_abs) << (30 - POS_FRAC_BITS);
        div_den = side ? DIST_W'(rym) : DIST_W'(rxm);
      end
      DS_LINE: begin
        div_num = DN_W'({scr_h, 16'b0});
        div_den = perp;
      end
      default: ;
    endcase
  end

  rc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign st.div_done = div_done;

  // ray setup multiplier, shared between the axes
  logic signed [CFG_W-1:0]       mul_a;
  logic signed [CFG_W+CAM_W-1:0] prod;
  logic signed [CFG_W-1:0]       mul_dir;
  logic signed [RAY_W-1:0]       ray_new;

  assign mul_a   = cmd.mul_y ? plane_y : plane_x;
  assign mul_dir = cmd.mul_y ? dir_y : dir_x;
  assign prod    = (CFG_W+CAM_W)'(mul_a) * (CFG_W+CAM_W)'(cam);
  assign ray_new = RAY_W'(mul_dir) + RAY_W'(prod >>> 14);

  // first side distance multiplier
  logic [FRAC_W-1:0] frac;
  logic [SP_W-1:0]   sp_full;
  logic [DIST_W-1:0] sp_sat;

  always_comb begin
    logic [POS_FRAC_BITS-1:0] f;
    logic                     neg;
    logic [DIST_W-1:0]        d;
    if (cmd.side_y) begin
      f = pos_y[POS_FRAC_BITS-1:0]; neg = ray_y[RAY_W-1]; d = dy;
    end else begin
      f = pos_x[POS_FRAC_BITS-1:0]; neg = ray_x[RAY_W-1]; d = dx;
    end
    frac    = neg ? FRAC_W'(f) : (FRAC_W'(1) << POS_FRAC_BITS) - FRAC_W'(f);
    sp_full = (SP_W'(frac) * SP_W'(d)) >> POS_FRAC_BITS;
    sp_sat  = (|sp_full[SP_W-1:DIST_W]) ? DIST_MAX : sp_full[DIST_W-1:0];
  end

  // walk step
  logic                    x_step;
  logic signed [CRD_W-1:0] mx_next, my_next;
  logic [DIST_W:0]         sum_x, sum_y;
  logic                    nxt_in, cur_in;

  assign x_step  = sdx < sdy;
  assign sum_x   = {1'b0, sdx} + {1'b0, dx};
  assign sum_y   = {1'b0, sdy} + {1'b0, dy};
  assign mx_next = x_step ? (ray_x[RAY_W-1] ? mx - 1'b1 : mx + 1'b1) : mx;
  assign my_next = x_step ? my : (ray_y[RAY_W-1] ? my - 1'b1 : my + 1'b1);
  assign nxt_in  = !mx_next[CRD_W-1] && !my_next[CRD_W-1] &&
                   (mx_next < CRD_W'(MAP_DIM)) && (my_next < CRD_W'(MAP_DIM));
  assign cur_in  = !mx[CRD_W-1] && !my[CRD_W-1] &&
                   (mx < CRD_W'(MAP_DIM)) && (my < CRD_W'(MAP_DIM));
  assign rd_en   = cmd.walk_step && nxt_in;
  assign rd_addr = AW'(mx_next[MAP_W-1:0]) * AW'(MAP_DIM) + AW'(my_next[MAP_W-1:0]);

  assign st.walk_out  = !cur_in;
  assign st.walk_wall = (rd_data != 3'd0);

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      col_q <= column;
      mx    <= CRD_W'(pos_x >> POS_FRAC_BITS);
      my    <= CRD_W'(pos_y >> POS_FRAC_BITS);
      side  <= 1'b0;
    end
    if (cmd.div_start) div_sel_q <= cmd.div_sel;
    if (div_done) begin
      unique case (div_sel_q)
        DS_CAM:  cam <= $signed({1'b0, div_q[CAM_W-2:0]}) - CAM_W'(16384);
        DS_INVX: dx  <= (rxm == '0) ? DIST_MAX : div_q[DIST_W-1:0];
        DS_INVY: dy  <= (rym == '0) ? DIST_MAX : div_q[DIST_W-1:0];
        DS_PERP: begin
          if (((side ? rym : rxm) == '0) || (|div_q[DN_W-1:DIST_W])) perp <= DIST_MAX;
          else if (div_q[DIST_W-1:0] == '0) perp <= DIST_W'(1);
          else perp <= div_q[DIST_W-1:0];
        end
        DS_LINE: lh <= div_q[LH_W-1:0];
        default: ;
      endcase
    end
    if (cmd.mul_x) ray_x <= ray_new;
    if (cmd.mul_y) ray_y <= ray_new;
    if (cmd.side_x) sdx <= sp_sat;
    if (cmd.side_y) sdy <= sp_sat;
    if (cmd.walk_step) begin
      mx   <= mx_next;
      my   <= my_next;
      side <= !x_step;
      if (x_step) sdx <= sum_x[DIST_W] ? DIST_MAX : sum_x[DIST_W-1:0];
      else        sdy <= sum_y[DIST_W] ? DIST_MAX : sum_y[DIST_W-1:0];
    end
    if (cmd.walk_end) begin
      hit   <= cur_in;
      wtype <= rd_data;
    end
  end

  // result register
  logic [23:0]              rgb;
  logic signed [LH_W+1:0]   half_h, half_lh;

  assign rgb     = wall_rgb(wtype);
  assign half_h  = (LH_W+2)'(scr_h[DIM_W-1:1]);
  assign half_lh = (LH_W+2)'(lh[LH_W-1:1]);
  assign st.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready)    out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_column <= col_q;
      wall_hit   <= hit;
      if (hit) begin
        hit_side    <= side;
        wall_type   <= wtype;
        slice_start <= clamp(half_h - half_lh);
        slice_end   <= clamp(half_h + half_lh);
        red         <= side ? {1'b0, rgb[23:17]} : rgb[23:16];
        green       <= side ? {1'b0, rgb[15:9]}  : rgb[15:8];
        blue        <= side ? {1'b0, rgb[7:1]}   : rgb[7:0];
      end else begin
        hit_side    <= 1'b0;
        wall_type   <= 3'd0;
        slice_start <= '0;
        slice_end   <= '0;
        red         <= 8'd0;
        green       <= 8'd0;
        blue        <= 8'd0;
      end
    end
  end

endmodule

// ----- design/grid_dda_column_raycaster.sv -----
// Column ray caster over a MAP_DIM x MAP_DIM map of wall types. An opcode 0
// transaction writes one map cell (cells outside the map are ignored) and is
// taken with no result, leaving the controller idle; an opcode 1 transaction
// casts the ray of one screen column and returns one result. A cast runs one
// item at a time. A cast that hits a wall runs five divisions, one that leaves
// the map three: up to five divisions (camera x, the two inverse ray
// components, the perpendicular distance and the slice height) share one
// divider that yields one quotient bit per cycle over 40 bits, and each map
// step of the ray reads the map store and then tests the cell. A result
// waiting in the output register does not stop the next transaction from
// being taken; a later cast that finishes while it still waits holds in_ready
// low until it is taken. After reset the map store is cleared one cell per
// cycle over all MAP_DIM * MAP_DIM cells, during which in_ready stays low;
// configuration writes are taken at any time but belong only to idle periods.
module grid_dda_column_raycaster
  import rc_pkg::*;
#(
  parameter int MAP_DIM       = MAP_DIM_DEF,
  parameter int POS_FRAC_BITS = POS_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic [COL_W-1:0]          column,
  input  logic [3:0]                cell_x,
  input  logic [3:0]                cell_y,
  input  logic [2:0]                cell_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COL_W-1:0]          out_column,
  output logic                      wall_hit,
  output logic                      hit_side,
  output logic [2:0]                wall_type,
  output logic signed [SLICE_W-1:0] slice_start,
  output logic signed [SLICE_W-1:0] slice_end,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue
);

  cmd_t  cmd;
  stat_t st;

  rc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rc_datapath #(
    .MAP_DIM       (MAP_DIM),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .column      (column),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_value  (cell_value),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_column  (out_column),
    .wall_hit    (wall_hit),
    .hit_side    (hit_side),
    .wall_type   (wall_type),
    .slice_start (slice_start),
    .slice_end   (slice_end),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

endmodule
